[rtl/bst_pkg.sv]
// Package for the bounded set table: field widths, command and status codes,
// sequencer states and default sizing. No dependencies.

package bst_pkg;

    localparam int DEFAULT_MAX_ELEMENTS = 64;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_PRESENT = 2'd2,
        STATUS_ABSENT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

[rtl/bst_cmd_if.sv]
// Command channel of the bounded set table: valid/ready plus command and value.
// Depends on bst_pkg for the field widths.

interface bst_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [bst_pkg::CMD_W-1:0]           command;
    logic signed [bst_pkg::VALUE_W-1:0]  value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

[rtl/bst_rsp_if.sv]
// Result channel of the bounded set table: valid/ready plus one result item.
// Depends on bst_pkg for the field widths.

interface bst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bst_pkg::STATUS_W-1:0]        status;
    logic                                was_present;
    logic [bst_pkg::COUNT_W-1:0]         count;
    logic                                is_empty;
    logic                                extremes_valid;
    logic signed [bst_pkg::VALUE_W-1:0]  minimum;
    logic signed [bst_pkg::VALUE_W-1:0]  maximum;

    modport source (output valid, status, was_present, count, is_empty, extremes_valid,
                    minimum, maximum, input ready);
    modport sink   (input valid, status, was_present, count, is_empty, extremes_valid,
                    minimum, maximum, output ready);
endinterface

[rtl/bounded_set_table.sv]
// Bounded set table: distinct signed values in an unsorted store with one write and one read port.
// Depends on bst_pkg, bst_cmd_if and bst_rsp_if.
//
//   channel   dir   handshake        payload
//   cmd       in    valid/ready      command, value
//   rsp       out   valid/ready      status, was_present, count, is_empty,
//                                    extremes_valid, minimum, maximum
//   cfg       in    cfg_wr_en        cfg_wr_data (capacity)
//
// A command goes from its transfer through the scan and a final step to its result,
// and the next command can transfer in the same cycle that the result appears.
// The store is scanned one entry per cycle through its single registered read
// port, which finds the match, the last entry and the extremes in the same pass.
// The store needs no clearing after reset: only entries below the count are read.
// A finished result waits in the output register while the next command is taken;
// the sequencer holds in its final step only if that register is still occupied.

module bounded_set_table #(
    parameter int MAX_ELEMENTS = bst_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bst_cmd_if.sink                    cmd,
    bst_rsp_if.source                  rsp,
    input  logic                       cfg_wr_en,
    input  logic [bst_pkg::CAP_W-1:0]  cfg_wr_data
);

    localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW   = $clog2(MAX_ELEMENTS + 1);
    localparam int CMPW = (CW > bst_pkg::CAP_W) ? CW : bst_pkg::CAP_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    typedef logic signed [bst_pkg::VALUE_W-1:0] val_t;

    // store
    val_t              mem [MAX_ELEMENTS];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    val_t              mem_wdata;
    logic              rd_en;
    val_t              rd_data_reg;

    // control and scan state
    bst_pkg::state_t   state_reg, state_next;
    logic [bst_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [bst_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    val_t              val_reg, val_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     hit_reg, hit_next;
    val_t              last_reg, last_next;
    logic              exv_reg, exv_next;
    val_t              mn_reg, mn_next;
    val_t              mx_reg, mx_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    bst_pkg::status_t  out_status_reg, out_status_next;
    logic              out_present_reg, out_present_next;
    logic [bst_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic              out_xv_reg, out_xv_next;
    val_t              out_min_reg, out_min_next;
    val_t              out_max_reg, out_max_next;

    // finalize helpers
    logic              full;
    logic              incl;
    logic [CMPW-1:0]   cnt_ext;

    assign cmd.ready = (state_reg == bst_pkg::ST_IDLE);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.was_present    = out_present_reg;
    assign rsp.count          = out_count_reg;
    assign rsp.is_empty       = ~out_xv_reg;
    assign rsp.extremes_valid = out_xv_reg;
    assign rsp.minimum        = out_min_reg;
    assign rsp.maximum        = out_max_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bst_pkg::ST_IDLE;
            cap_reg       <= bst_pkg::CAP_RESET;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        cmd_reg         <= cmd_next;
        val_reg         <= val_next;
        found_reg       <= found_next;
        hit_reg         <= hit_next;
        last_reg        <= last_next;
        exv_reg         <= exv_next;
        mn_reg          <= mn_next;
        mx_reg          <= mx_next;
        out_status_reg  <= out_status_next;
        out_present_reg <= out_present_next;
        out_count_reg   <= out_count_next;
        out_xv_reg      <= out_xv_next;
        out_min_reg     <= out_min_next;
        out_max_reg     <= out_max_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        issue_next       = issue_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = issue_reg[AW-1:0];
        cmd_next         = cmd_reg;
        val_next         = val_reg;
        found_next       = found_reg;
        hit_next         = hit_reg;
        last_next        = last_reg;
        exv_next         = exv_reg;
        mn_next          = mn_reg;
        mx_next          = mx_reg;
        out_valid_next   = out_valid_reg & ~rsp.ready;
        out_status_next  = out_status_reg;
        out_present_next = out_present_reg;
        out_count_next   = out_count_reg;
        out_xv_next      = out_xv_reg;
        out_min_next     = out_min_reg;
        out_max_next     = out_max_reg;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg[AW-1:0];
        mem_wdata        = val_reg;
        rd_en            = 1'b0;
        cnt_ext          = CMPW'(cnt_reg);
        full             = (cnt_reg >= MAX_CNT) || (cnt_ext >= CMPW'(cap_reg));
        incl             = 1'b0;

        unique case (state_reg)
            bst_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.command;
                    val_next   = cmd.value;
                    issue_next = '0;
                    found_next = 1'b0;
                    exv_next   = 1'b0;
                    state_next = bst_pkg::ST_SCAN;
                end
            end

            bst_pkg::ST_SCAN:
            begin
                rd_en = (issue_reg < cnt_reg);
                if (rd_en)
                begin
                    issue_next  = CW'(issue_reg + 1'b1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    // the final read is the last entry, kept for a remove
                    last_next = rd_data_reg;
                    if (rd_data_reg == val_reg)
                    begin
                        found_next = 1'b1;
                        hit_next   = rd_idx_reg;
                    end
                    else
                    begin
                        // extremes over every entry except the matching one
                        if (!exv_reg || (rd_data_reg < mn_reg))
                        begin
                            mn_next = rd_data_reg;
                        end
                        if (!exv_reg || (rd_data_reg > mx_reg))
                        begin
                            mx_next = rd_data_reg;
                        end
                        exv_next = 1'b1;
                    end
                end
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = bst_pkg::ST_DONE;
                end
            end

            bst_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_present_next = found_reg;
                    priority if (cmd_reg == bst_pkg::CMD_INSERT)
                    begin
                        if (full)
                        begin
                            out_status_next = bst_pkg::STATUS_FULL;
                            incl            = found_reg;
                        end
                        else if (found_reg)
                        begin
                            out_status_next = bst_pkg::STATUS_PRESENT;
                            incl            = 1'b1;
                        end
                        else
                        begin
                            out_status_next = bst_pkg::STATUS_OK;
                            incl            = 1'b1;
                            mem_we          = 1'b1;
                            mem_waddr       = cnt_reg[AW-1:0];
                            mem_wdata       = val_reg;
                            cnt_next        = CW'(cnt_reg + 1'b1);
                        end
                    end
                    else if (cmd_reg == bst_pkg::CMD_REMOVE)
                    begin
                        if (found_reg)
                        begin
                            out_status_next = bst_pkg::STATUS_OK;
                            incl            = 1'b0;
                            mem_we          = 1'b1;
                            mem_waddr       = hit_reg;
                            mem_wdata       = last_reg;
                            cnt_next        = CW'(cnt_reg - 1'b1);
                        end
                        else
                        begin
                            out_status_next = bst_pkg::STATUS_ABSENT;
                        end
                    end
                    else
                    begin
                        out_status_next = found_reg ? bst_pkg::STATUS_OK
                                                    : bst_pkg::STATUS_ABSENT;
                        incl            = found_reg;
                    end

                    out_xv_next = exv_reg | incl;
                    priority if (exv_reg)
                    begin
                        out_min_next = (incl && (val_reg < mn_reg)) ? val_reg : mn_reg;
                        out_max_next = (incl && (val_reg > mx_reg)) ? val_reg : mx_reg;
                    end
                    else if (incl)
                    begin
                        out_min_next = val_reg;
                        out_max_next = val_reg;
                    end
                    else
                    begin
                        out_min_next = '0;
                        out_max_next = '0;
                    end
                    out_count_next = bst_pkg::COUNT_W'(CMPW'(cnt_next));
                    out_valid_next = 1'b1;
                    state_next     = bst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/bst_checker.sv]
// Port-level checks for the bounded set table, attached to it by bind.
// Depends on bst_pkg for the field widths; sees only the top-level ports.

module bst_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [bst_pkg::COUNT_W-1:0]        count,
    input  logic                               is_empty,
    input  logic                               extremes_valid,
    input  logic signed [bst_pkg::VALUE_W-1:0] minimum,
    input  logic signed [bst_pkg::VALUE_W-1:0] maximum
);

    // a command keeps the sequencer busy past its transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken again right after a transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count) && $stable(minimum))
        else $error("stalled result changed");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)) && (extremes_valid == !is_empty))
        else $error("empty flag disagrees with count or extremes flag");

    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && extremes_valid |-> minimum <= maximum)
        else $error("minimum above maximum");

endmodule

bind bounded_set_table bst_checker u_bst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd.valid),
    .in_ready       (cmd.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .count          (rsp.count),
    .is_empty       (rsp.is_empty),
    .extremes_valid (rsp.extremes_valid),
    .minimum        (rsp.minimum),
    .maximum        (rsp.maximum)
);
